// ===== hdl/mmbs_pkg.sv =====
package mmbs_pkg;

    localparam int PHASES_DEF = 3;
    localparam int RATES      = 4;
    localparam int SAMPLE_W   = 64;
    localparam int BYTE_W     = 8;
    localparam int CNT_W      = 8;

    localparam logic [SAMPLE_W-1:0] REF_RESET = 64'hffff_ffff_ffff_ffff;
    localparam logic [CNT_W-1:0]    CNT_MAX   = 8'hff;

    typedef enum logic [1:0] {
        OP_DECODE     = 2'd0,
        OP_READ_SLICE = 2'd1,
        OP_READ_BYTE  = 2'd2,
        OP_NONE       = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        RATE_800 = 2'd0,
        RATE_400 = 2'd1,
        RATE_200 = 2'd2,
        RATE_100 = 2'd3
    } t_rate;

    typedef struct packed {
        t_opcode              opcode;
        logic [1:0]           phase;
        logic [1:0]           rate_select;
        logic [SAMPLE_W-1:0]  sample_word;
    } t_in_word;

    typedef struct packed {
        logic               ready_res;
        logic [BYTE_W-1:0]  data_byte;
    } t_out_word;

    // Chunk votes of one sample word, first chunk in the MSB of each field.
    typedef struct packed {
        logic [7:0] v800;
        logic [3:0] v400;
        logic [1:0] v200;
        logic       v100;
    } t_votes;

    // One memory row holds every rate of one phase.
    typedef struct packed {
        logic [RATES-1:0][BYTE_W-1:0] rate_byte;
        logic [RATES-1:0][CNT_W-1:0]  bit_cnt;
    } t_row;

    // Phase reduced modulo the phase count; the phase is below four, so
    // three conditional subtractions are enough.
    function automatic logic [1:0] phase_mod(input logic [1:0] ph, input int phases);
        logic [2:0] r;
        r = {1'b0, ph};
        for (int i = 0; i < 3; i++) begin
            if (int'(r) >= phases) begin
                r = r - 3'(phases);
            end
        end
        return r[1:0];
    endfunction

    // Received bits that a read of the given kind needs.
    function automatic logic [3:0] need_bits(input t_opcode op, input logic [1:0] rate);
        logic [3:0] n;
        n = 4'd8;
        if (op == OP_READ_SLICE) begin
            n = 4'd8 >> rate;
        end
        return n;
    endfunction

endpackage

// ===== hdl/multirate_majority_bit_slicer_top.sv =====
// Multirate majority-vote bit slicer.
// Throughput: one word per cycle unless the consumer stalls. The per-phase row memory
// is read at acceptance into stage one, whose result goes to the output register; the
// row is written back as the word leaves stage one, and a same-row read is forwarded.
// Reset (synchronous, active low) sets the reference pattern to all ones and
// marks every memory row as unwritten, so all bytes and counters read as zero.
module multirate_majority_bit_slicer_top #(
    parameter int PHASES = mmbs_pkg::PHASES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mmbs_pkg::SAMPLE_W-1:0] i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  mmbs_pkg::t_in_word            i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output mmbs_pkg::t_out_word           o_out_word
);

    localparam int AW = (PHASES > 1) ? $clog2(PHASES) : 1;

    // The reference pattern must be written only while idle; the block does not enforce it.
    logic [mmbs_pkg::SAMPLE_W-1:0] r_ref_pattern;

    // Stage one: the accepted word with its votes; its memory row arrives
    // from the row memory during this stage.
    logic              r_s1_vld;
    mmbs_pkg::t_opcode r_s1_op;
    logic [1:0]        r_s1_rate;
    mmbs_pkg::t_votes  r_s1_votes;
    logic [AW-1:0]     r_s1_addr;

    // Output register.
    logic                r_out_vld;
    mmbs_pkg::t_out_word r_out_word;

    logic                in_acc;
    logic                s1_move;
    logic [AW-1:0]       in_addr;
    mmbs_pkg::t_votes    in_votes;
    mmbs_pkg::t_row      rd_row;
    mmbs_pkg::t_row      wr_row;
    mmbs_pkg::t_out_word s1_word;

    // Stage one moves into the output register whenever that register is
    // empty or being emptied, so a waiting result never blocks a new word
    // unless the consumer itself stalls.
    assign s1_move    = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_s1_vld || s1_move;
    assign in_acc     = i_in_valid && o_in_ready;

    assign in_addr = AW'(mmbs_pkg::phase_mod(i_in_word.phase, PHASES));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_pattern <= mmbs_pkg::REF_RESET;
        end else if (i_cfg_we) begin
            r_ref_pattern <= i_cfg_wdata;
        end
    end

    mmbs_vote u_vote (
        .i_sample_word (i_in_word.sample_word),
        .i_ref_pattern (r_ref_pattern),
        .o_votes       (in_votes)
    );

    // The read is enabled only at acceptance, so the row data holds while
    // stage one is stalled; only stage one writes, so it cannot go stale.
    mmbs_row_mem #(
        .PHASES (PHASES),
        .AW     (AW)
    ) u_row_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_addr (in_addr),
        .i_wr_en   (s1_move),
        .i_wr_addr (r_s1_addr),
        .i_wr_row  (wr_row),
        .o_rd_row  (rd_row)
    );

    mmbs_update u_update (
        .i_opcode (r_s1_op),
        .i_rate   (r_s1_rate),
        .i_votes  (r_s1_votes),
        .i_row    (rd_row),
        .o_row    (wr_row),
        .o_word   (s1_word)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_move) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_move) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_op    <= i_in_word.opcode;
            r_s1_rate  <= i_in_word.rate_select;
            r_s1_votes <= in_votes;
            r_s1_addr  <= in_addr;
        end
        if (s1_move) begin
            r_out_word <= s1_word;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

endmodule

// ===== hdl/mmbs_vote.sv =====
module mmbs_vote (
    input  logic [mmbs_pkg::SAMPLE_W-1:0] i_sample_word,
    input  logic [mmbs_pkg::SAMPLE_W-1:0] i_ref_pattern,
    output mmbs_pkg::t_votes              o_votes
);

    logic [mmbs_pkg::SAMPLE_W-1:0] w;
    logic [7:0][3:0] c8;
    logic [3:0][4:0] c16;
    logic [1:0][5:0] c32;
    logic [6:0]      c64;

    assign w = i_sample_word ^ i_ref_pattern;

    // Chunk 0 is the most significant byte.
    always_comb begin
        for (int j = 0; j < 8; j++) begin
            c8[j] = '0;
            for (int b = 0; b < 8; b++) begin
                c8[j] = c8[j] + 4'(w[63 - 8*j - b]);
            end
        end
        for (int j = 0; j < 4; j++) begin
            c16[j] = 5'(c8[2*j]) + 5'(c8[2*j+1]);
        end
        for (int j = 0; j < 2; j++) begin
            c32[j] = 6'(c16[2*j]) + 6'(c16[2*j+1]);
        end
        c64 = 7'(c32[0]) + 7'(c32[1]);
    end

    // A chunk votes one when at most half of its bits are set.
    always_comb begin
        for (int j = 0; j < 8; j++) begin
            o_votes.v800[7-j] = (c8[j] <= 4'd4);
        end
        for (int j = 0; j < 4; j++) begin
            o_votes.v400[3-j] = (c16[j] <= 5'd8);
        end
        for (int j = 0; j < 2; j++) begin
            o_votes.v200[1-j] = (c32[j] <= 6'd16);
        end
        o_votes.v100 = (c64 <= 7'd32);
    end

endmodule

// ===== hdl/mmbs_row_mem.sv =====
module mmbs_row_mem #(
    parameter int PHASES = mmbs_pkg::PHASES_DEF,
    parameter int AW     = (PHASES > 1) ? $clog2(PHASES) : 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_rd_en,
    input  logic [AW-1:0]   i_rd_addr,
    input  logic            i_wr_en,
    input  logic [AW-1:0]   i_wr_addr,
    input  mmbs_pkg::t_row  i_wr_row,
    output mmbs_pkg::t_row  o_rd_row
);

    mmbs_pkg::t_row mem [PHASES];
    mmbs_pkg::t_row r_q;
    mmbs_pkg::t_row r_fwd_row;
    logic [PHASES-1:0] r_vld;
    logic r_rd_vld;
    logic r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_row;
        end
        if (i_rd_en) begin
            r_q       <= mem[i_rd_addr];
            r_fwd_row <= i_wr_row;
        end
    end

    // A row never written reads as zero; a write in the same cycle as the
    // read of that row is forwarded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_fwd    <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
                r_fwd    <= i_wr_en && (i_wr_addr == i_rd_addr);
            end
        end
    end

    always_comb begin
        if (r_fwd) begin
            o_rd_row = r_fwd_row;
        end else if (r_rd_vld) begin
            o_rd_row = r_q;
        end else begin
            o_rd_row = '0;
        end
    end

endmodule

// ===== hdl/mmbs_update.sv =====
module mmbs_update (
    input  mmbs_pkg::t_opcode    i_opcode,
    input  logic [1:0]           i_rate,
    input  mmbs_pkg::t_votes     i_votes,
    input  mmbs_pkg::t_row       i_row,
    output mmbs_pkg::t_row       o_row,
    output mmbs_pkg::t_out_word  o_word
);

    logic [3:0] need;
    logic       enough;

    assign need   = mmbs_pkg::need_bits(i_opcode, i_rate);
    assign enough = (i_row.bit_cnt[i_rate] >= mmbs_pkg::CNT_W'(need));

    function automatic logic [mmbs_pkg::CNT_W-1:0] sat_add(
        input logic [mmbs_pkg::CNT_W-1:0] c, input logic [3:0] n);
        logic [mmbs_pkg::CNT_W:0] s;
        s = {1'b0, c} + (mmbs_pkg::CNT_W+1)'(n);
        return s[mmbs_pkg::CNT_W] ? mmbs_pkg::CNT_MAX : s[mmbs_pkg::CNT_W-1:0];
    endfunction

    always_comb begin
        o_row  = i_row;
        o_word = '0;
        case (i_opcode)
            mmbs_pkg::OP_DECODE: begin
                o_row.rate_byte[mmbs_pkg::RATE_800] = i_votes.v800;
                o_row.rate_byte[mmbs_pkg::RATE_400] =
                    {i_row.rate_byte[mmbs_pkg::RATE_400][3:0], i_votes.v400};
                o_row.rate_byte[mmbs_pkg::RATE_200] =
                    {i_row.rate_byte[mmbs_pkg::RATE_200][5:0], i_votes.v200};
                o_row.rate_byte[mmbs_pkg::RATE_100] =
                    {i_row.rate_byte[mmbs_pkg::RATE_100][6:0], i_votes.v100};
                o_row.bit_cnt[mmbs_pkg::RATE_800] =
                    sat_add(i_row.bit_cnt[mmbs_pkg::RATE_800], 4'd8);
                o_row.bit_cnt[mmbs_pkg::RATE_400] =
                    sat_add(i_row.bit_cnt[mmbs_pkg::RATE_400], 4'd4);
                o_row.bit_cnt[mmbs_pkg::RATE_200] =
                    sat_add(i_row.bit_cnt[mmbs_pkg::RATE_200], 4'd2);
                o_row.bit_cnt[mmbs_pkg::RATE_100] =
                    sat_add(i_row.bit_cnt[mmbs_pkg::RATE_100], 4'd1);
                o_word.data_byte = i_votes.v800;
            end
            mmbs_pkg::OP_READ_SLICE, mmbs_pkg::OP_READ_BYTE: begin
                if (enough) begin
                    o_word.ready_res     = 1'b1;
                    o_word.data_byte     = i_row.rate_byte[i_rate];
                    o_row.bit_cnt[i_rate] = '0;
                end
            end
            default: begin
            end
        endcase
    end

endmodule
